// ----- rtl/core/multilevel_ready_queue_unit_defines.svh -----
// assertion helpers for the ready queue unit rtl
`ifndef MULTILEVEL_READY_QUEUE_UNIT_DEFINES_SVH
`define MULTILEVEL_READY_QUEUE_UNIT_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define MLRQ_CHECK(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define MLRQ_CHECK_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/mlrq_pkg.sv -----
`timescale 1ns / 1ps

package mlrq_pkg;

    // fixed field widths of the item channels
    localparam int ID_W  = 6;
    localparam int LVL_W = 5;

    // command codes
    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_PICK   = 2'd2;

    // status codes
    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_DUP  = 2'd2;

    typedef struct packed {
        logic [1:0]       cmd;
        logic [ID_W-1:0]  thread_id;
        logic [LVL_W-1:0] priority_req;
    } mlrq_in_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [ID_W-1:0]  picked_thread;
        logic [LVL_W-1:0] picked_level;
    } mlrq_out_t;

endpackage

// ----- rtl/core/multilevel_ready_queue_unit.sv -----
`timescale 1ns / 1ps
`include "multilevel_ready_queue_unit_defines.svh"

// Ready queue scheduler: one FIFO of thread ids per priority level.
// Input channel s_valid/s_ready/s_item carries a command (insert, remove,
// pick), a thread id and a priority level. Result channel m_valid/m_ready/
// m_item returns one item per command: status, picked thread, picked level.
// Pick serves the head of the lowest-numbered non-empty level.
// An accepted command is held in the execute register and its result is
// registered into the output register behind m_valid and m_item.
// Throughput: one command per cycle while results are taken. Link
// memories are read at accept and the command executes in the following
// cycle against the forwarded data; the find-first over level flags and
// the head select set the cycle. Reset (aresetn low, synchronous) empties
// every level, then the thread status memory is cleared one entry per
// cycle; s_ready stays low during that pass.
// When the receiver stalls, the result stays in the output register, one
// more command is taken into the execute register, and s_ready then drops
// until the result is taken.
module multilevel_ready_queue_unit
    import mlrq_pkg::*;
#(
    parameter int NUM_THREADS = 64,
    parameter int NUM_LEVELS  = 32
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  mlrq_in_t  s_item,
    output logic      m_valid,
    input  logic      m_ready,
    output mlrq_out_t m_item
);

    localparam int TIW = $clog2(NUM_THREADS);
    localparam int LIW = $clog2(NUM_LEVELS);
    localparam int THW = LIW + 1;

    // level table: head, tail and non-empty flag per level
    logic [TIW-1:0]        lvl_head_reg [NUM_LEVELS];
    logic [TIW-1:0]        lvl_tail_reg [NUM_LEVELS];
    logic [NUM_LEVELS-1:0] lvl_ne_reg;
    logic [NUM_LEVELS-1:0] lvl_ne_next;

    // clear pass of thread status memory
    logic           clr_active_reg;
    logic [TIW-1:0] clr_addr_reg;

    // execute register
    logic           x_valid_reg;
    logic [1:0]     x_cmd_reg;
    logic [TIW-1:0] x_tid_reg;
    logic [LIW-1:0] x_lvl_reg;
    logic           x_rng_ok_reg;
    logic           x_ne_reg;
    logic [TIW-1:0] x_head_reg;
    logic [TIW-1:0] x_tail_reg;
    logic [TIW-1:0] x_nrd_reg;

    // forwarding of the write made at the read edge
    logic           nf_en_reg;
    logic [TIW-1:0] nf_addr_reg;
    logic [TIW-1:0] nf_data_reg;
    logic           pf_en_reg;
    logic [TIW-1:0] pf_addr_reg;
    logic [TIW-1:0] pf_data_reg;
    logic           tf_en_reg;
    logic [TIW-1:0] tf_addr_reg;
    logic [THW-1:0] tf_data_reg;

    // output register
    logic      m_valid_reg;
    mlrq_out_t m_item_reg;
    mlrq_out_t res_next;

    // memory ports
    logic [TIW-1:0] next_rdata;
    logic [TIW-1:0] prev_rdata;
    logic [THW-1:0] thr_rdata;
    logic           thr_we;
    logic [TIW-1:0] thr_waddr;
    logic [THW-1:0] thr_wdata;

    // execute stage signals
    logic           out_free;
    logic           x_fire;
    logic           s_fire;
    logic [TIW-1:0] nx_q;
    logic [TIW-1:0] pv_q;
    logic [THW-1:0] th_q;
    logic           th_queued;
    logic [LIW-1:0] th_lvl;
    logic [1:0]     res_status;
    logic           lw_en;
    logic           lw_ne;
    logic [TIW-1:0] lw_head;
    logic [TIW-1:0] lw_tail;
    logic           nw_en;
    logic [TIW-1:0] nw_addr;
    logic [TIW-1:0] nw_data;
    logic           pw_en;
    logic [TIW-1:0] pw_addr;
    logic [TIW-1:0] pw_data;
    logic           tw_en;
    logic [TIW-1:0] tw_addr;
    logic [THW-1:0] tw_data;

    // accept stage signals
    logic           pick_any;
    logic [LIW-1:0] pick_lvl;
    logic           acc_pick;
    logic [LIW-1:0] acc_lvl;
    logic           acc_ne;
    logic           lw_hit;
    logic [TIW-1:0] acc_head;
    logic [TIW-1:0] acc_tail;
    logic [TIW-1:0] acc_tid;
    logic [TIW-1:0] acc_nrd;
    logic           acc_rng;

    // handshake
    assign out_free = !m_valid_reg || m_ready;
    assign x_fire   = x_valid_reg && out_free;
    assign s_ready  = !clr_active_reg && (!x_valid_reg || out_free);
    assign s_fire   = s_valid && s_ready;
    assign m_valid  = m_valid_reg;
    assign m_item   = m_item_reg;

    // memory data with the same-edge write forwarded
    assign nx_q = (nf_en_reg && nf_addr_reg == x_nrd_reg) ? nf_data_reg : next_rdata;
    assign pv_q = (pf_en_reg && pf_addr_reg == x_tid_reg) ? pf_data_reg : prev_rdata;
    assign th_q = (tf_en_reg && tf_addr_reg == x_tid_reg) ? tf_data_reg : thr_rdata;
    assign th_queued = th_q[LIW];
    assign th_lvl    = th_q[LIW-1:0];

    // execute one command: status, level update and link writes
    always_comb begin
        res_status = ST_MISS;
        lw_en      = 1'b0;
        lw_ne      = x_ne_reg;
        lw_head    = x_head_reg;
        lw_tail    = x_tail_reg;
        nw_en      = 1'b0;
        nw_addr    = x_tail_reg;
        nw_data    = x_tid_reg;
        pw_en      = 1'b0;
        pw_addr    = x_tid_reg;
        pw_data    = x_tail_reg;
        tw_en      = 1'b0;
        tw_addr    = x_tid_reg;
        tw_data    = '0;
        res_next   = '0;
        case (x_cmd_reg)
            CMD_INSERT: begin
                if (x_rng_ok_reg) begin
                    if (th_queued) begin
                        res_status = ST_DUP;
                    end else begin
                        res_status = ST_DONE;
                        lw_en      = 1'b1;
                        lw_ne      = 1'b1;
                        lw_tail    = x_tid_reg;
                        tw_en      = 1'b1;
                        tw_data    = {1'b1, x_lvl_reg};
                        if (!x_ne_reg) begin
                            lw_head = x_tid_reg;
                        end else begin
                            // append behind the old tail
                            nw_en = 1'b1;
                            pw_en = 1'b1;
                        end
                    end
                end
            end
            CMD_REMOVE: begin
                if (x_rng_ok_reg && th_queued && th_lvl == x_lvl_reg) begin
                    res_status = ST_DONE;
                    lw_en      = 1'b1;
                    tw_en      = 1'b1;
                    if (x_head_reg == x_tail_reg) begin
                        lw_ne = 1'b0;
                    end else if (x_tid_reg == x_head_reg) begin
                        lw_head = nx_q;
                    end else if (x_tid_reg == x_tail_reg) begin
                        lw_tail = pv_q;
                    end else begin
                        // unlink from the middle of the list
                        nw_en   = 1'b1;
                        nw_addr = pv_q;
                        nw_data = nx_q;
                        pw_en   = 1'b1;
                        pw_addr = nx_q;
                        pw_data = pv_q;
                    end
                end
            end
            CMD_PICK: begin
                if (x_ne_reg) begin
                    res_status             = ST_DONE;
                    res_next.picked_thread = ID_W'(x_head_reg);
                    res_next.picked_level  = LVL_W'(x_lvl_reg);
                    lw_en                  = 1'b1;
                    tw_en                  = 1'b1;
                    tw_addr                = x_head_reg;
                    if (x_head_reg == x_tail_reg) begin
                        lw_ne = 1'b0;
                    end else begin
                        lw_head = nx_q;
                    end
                end
            end
            default: begin
            end
        endcase
        res_next.status = res_status;
    end

    // level flags as they stand after this cycle's commit
    always_comb begin
        lvl_ne_next = lvl_ne_reg;
        if (x_fire && lw_en) begin
            lvl_ne_next[x_lvl_reg] = lw_ne;
        end
    end

    // find first non-empty level
    always_comb begin
        pick_any = 1'b0;
        pick_lvl = '0;
        for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
            if (lvl_ne_next[i]) begin
                pick_any = 1'b1;
                pick_lvl = LIW'(i);
            end
        end
    end

    // accept side: level lookup with bypass of the committing command
    assign acc_pick = s_item.cmd == CMD_PICK;
    assign acc_lvl  = acc_pick ? pick_lvl : LIW'(s_item.priority_req);
    assign acc_ne   = acc_pick ? pick_any : lvl_ne_next[acc_lvl];
    assign lw_hit   = x_fire && lw_en && (x_lvl_reg == acc_lvl);
    assign acc_head = lw_hit ? lw_head : lvl_head_reg[acc_lvl];
    assign acc_tail = lw_hit ? lw_tail : lvl_tail_reg[acc_lvl];
    assign acc_tid  = TIW'(s_item.thread_id);
    assign acc_nrd  = acc_pick ? acc_head : acc_tid;
    assign acc_rng  = (32'(s_item.thread_id) < NUM_THREADS)
                   && (32'(s_item.priority_req) < NUM_LEVELS);

    // thread status write port, shared with the clear pass
    always_comb begin
        if (clr_active_reg) begin
            thr_we    = 1'b1;
            thr_waddr = clr_addr_reg;
            thr_wdata = '0;
        end else begin
            thr_we    = x_fire && tw_en;
            thr_waddr = tw_addr;
            thr_wdata = tw_data;
        end
    end

    mlrq_ram #(
        .WIDTH (TIW),
        .DEPTH (NUM_THREADS)
    ) u_next_ram (
        .aclk  (aclk),
        .we    (x_fire && nw_en),
        .waddr (nw_addr),
        .wdata (nw_data),
        .re    (s_fire),
        .raddr (acc_nrd),
        .rdata (next_rdata)
    );

    mlrq_ram #(
        .WIDTH (TIW),
        .DEPTH (NUM_THREADS)
    ) u_prev_ram (
        .aclk  (aclk),
        .we    (x_fire && pw_en),
        .waddr (pw_addr),
        .wdata (pw_data),
        .re    (s_fire),
        .raddr (acc_tid),
        .rdata (prev_rdata)
    );

    mlrq_ram #(
        .WIDTH (THW),
        .DEPTH (NUM_THREADS)
    ) u_thr_ram (
        .aclk  (aclk),
        .we    (thr_we),
        .waddr (thr_waddr),
        .wdata (thr_wdata),
        .re    (s_fire),
        .raddr (acc_tid),
        .rdata (thr_rdata)
    );

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
            lvl_ne_reg     <= '0;
            x_valid_reg    <= 1'b0;
            m_valid_reg    <= 1'b0;
            nf_en_reg      <= 1'b0;
            pf_en_reg      <= 1'b0;
            tf_en_reg      <= 1'b0;
        end else begin
            if (clr_active_reg) begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
                if (clr_addr_reg == TIW'(NUM_THREADS - 1)) begin
                    clr_active_reg <= 1'b0;
                end
            end
            lvl_ne_reg <= lvl_ne_next;
            if (s_fire) begin
                x_valid_reg <= 1'b1;
                nf_en_reg   <= x_fire && nw_en;
                pf_en_reg   <= x_fire && pw_en;
                tf_en_reg   <= x_fire && tw_en;
            end else if (x_fire) begin
                x_valid_reg <= 1'b0;
            end
            if (x_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            x_cmd_reg    <= s_item.cmd;
            x_tid_reg    <= acc_tid;
            x_lvl_reg    <= acc_lvl;
            x_rng_ok_reg <= acc_rng;
            x_ne_reg     <= acc_ne;
            x_head_reg   <= acc_head;
            x_tail_reg   <= acc_tail;
            x_nrd_reg    <= acc_nrd;
            nf_addr_reg  <= nw_addr;
            nf_data_reg  <= nw_data;
            pf_addr_reg  <= pw_addr;
            pf_data_reg  <= pw_data;
            tf_addr_reg  <= tw_addr;
            tf_data_reg  <= tw_data;
        end
        if (x_fire) begin
            m_item_reg <= res_next;
        end
        if (x_fire && lw_en) begin
            lvl_head_reg[x_lvl_reg] <= lw_head;
            lvl_tail_reg[x_lvl_reg] <= lw_tail;
        end
    end

    `MLRQ_CHECK(a_no_accept_in_clear, aclk, aresetn, clr_active_reg, !s_ready,
        "item accepted during clear pass")
    `MLRQ_CHECK(a_pick_from_live_level, aclk, aresetn,
        x_fire && x_cmd_reg == CMD_PICK && res_status == ST_DONE,
        lvl_ne_reg[x_lvl_reg], "pick served an empty level")
    `MLRQ_CHECK(a_empty_only_single, aclk, aresetn, x_fire && lw_en && !lw_ne,
        x_head_reg == x_tail_reg, "level emptied while holding several threads")
    `MLRQ_CHECK_NEXT(a_flag_update, aclk, aresetn, x_fire && lw_en,
        lvl_ne_reg[$past(x_lvl_reg)] == $past(lw_ne), "level flag not updated")

endmodule

// ----- rtl/core/mlrq_ram.sv -----
`timescale 1ns / 1ps

module mlrq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port, read returns old data on collision
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule
